// ===== rtl/ctc_pkg.sv =====
package ctc_pkg;

    localparam int MAX_TRIPLES_DEF = 16;
    localparam int Q_FRAC          = 16;
    localparam int PROB_W          = 17;
    localparam int ID_W            = 32;

    localparam logic [PROB_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [PROB_W-1:0] ZERO_Q16 = 17'h00000;

    localparam logic MODE_INDEPENDENT = 1'b0;
    localparam logic MODE_CONDITION   = 1'b1;

    typedef struct packed {
        logic signed [ID_W-1:0] var_id;
        logic signed [ID_W-1:0] value_id;
        logic [PROB_W-1:0]      probability;
        logic                   last;
    } t_in_req;

    typedef struct packed {
        logic [PROB_W-1:0] confidence;
        logic              conflict;
        logic              overflow;
    } t_out_req;

    typedef struct packed {
        logic signed [ID_W-1:0] var_id;
        logic signed [ID_W-1:0] value_id;
    } t_pair;

    typedef struct packed {
        logic match;
        logic differ;
    } t_cell_hit;

endpackage

// ===== rtl/condition_triple_confidence_top.sv =====
// Channel  Valid        Stall        Payload
// input    i_in_valid   o_in_stall   i_in_req  (t_in_req)
// output   o_out_valid  i_out_stall  o_out_req (t_out_req)
// config   i_cfg_we     -            i_cfg_wdata (mode)
//
// One request per cycle unless o_in_stall; the result is registered in the cycle
// after its last-marked request.
// Reset: synchronous active low; condition mode, product one, count and flags zero.
// Input stalls only while a result is held and the output is stalled.
module condition_triple_confidence_top
    import ctc_pkg::*;
#(
    parameter int MAX_TRIPLES = MAX_TRIPLES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    localparam int CW = $clog2(MAX_TRIPLES + 1);

    logic                r_mode;
    logic [CW-1:0]       r_count,    n_count;
    logic [PROB_W-1:0]   r_prod,     n_prod;
    logic                r_conflict, n_conflict;
    logic                r_overflow, n_overflow;
    logic                r_out_valid;
    t_out_req            r_out_req;

    logic                in_acc;
    logic                store;
    logic                found;
    logic                differ;
    logic [PROB_W-1:0]   p_sat;
    logic [2*PROB_W-1:0] mul;
    logic [PROB_W-1:0]   mul_q;
    t_pair               query;
    t_pair               chain [MAX_TRIPLES+1];
    t_cell_hit           hits  [MAX_TRIPLES];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign query.var_id   = i_in_req.var_id;
    assign query.value_id = i_in_req.value_id;
    assign chain[0]       = query;

    genvar k;
    generate
        for (k = 0; k < MAX_TRIPLES; k++) begin : g_cell
            ctc_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (store),
                .i_active (r_count > CW'(k)),
                .i_pair   (chain[k]),
                .i_query  (query),
                .o_pair   (chain[k+1]),
                .o_hit    (hits[k])
            );
        end
    endgenerate

    always_comb begin
        found  = 1'b0;
        differ = 1'b0;
        for (int j = 0; j < MAX_TRIPLES; j++) begin
            found  = found  | hits[j].match;
            differ = differ | hits[j].differ;
        end
    end

    assign p_sat = i_in_req.probability[PROB_W-1] ? ONE_Q16 : i_in_req.probability;
    assign mul   = r_prod * p_sat;
    assign mul_q = mul[Q_FRAC+PROB_W-1:Q_FRAC];

    always_comb begin
        n_count    = r_count;
        n_prod     = r_prod;
        n_conflict = r_conflict;
        n_overflow = r_overflow;
        store      = 1'b0;
        if (in_acc) begin
            if (r_mode == MODE_INDEPENDENT) begin
                n_prod = mul_q;
            end else if (found) begin
                if (differ) begin
                    n_prod     = ZERO_Q16;
                    n_conflict = 1'b1;
                end
            end else begin
                n_prod = mul_q;
                if (r_count < CW'(MAX_TRIPLES)) begin
                    store   = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    n_overflow = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_CONDITION;
            r_count     <= '0;
            r_prod      <= ONE_Q16;
            r_conflict  <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (in_acc && i_in_req.last) begin
                r_count     <= '0;
                r_prod      <= ONE_Q16;
                r_conflict  <= 1'b0;
                r_overflow  <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                r_count    <= n_count;
                r_prod     <= n_prod;
                r_conflict <= n_conflict;
                r_overflow <= n_overflow;
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_req.last) begin
            r_out_req.confidence <= n_prod;
            r_out_req.conflict   <= n_conflict;
            r_out_req.overflow   <= n_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TRIPLES))
        else $error("entry count beyond store depth");

    a_tuple_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_req.last |=> r_count == '0 && r_prod == ONE_Q16 && o_out_valid)
        else $error("tuple state not cleared after last request");

    a_conflict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conflict |-> r_prod == ZERO_Q16)
        else $error("conflict with nonzero product");
`endif

endmodule

// ===== rtl/ctc_cell.sv =====
module ctc_cell
    import ctc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_shift,
    input  logic      i_active,
    input  t_pair     i_pair,
    input  t_pair     i_query,
    output t_pair     o_pair,
    output t_cell_hit o_hit
);

    t_pair r_pair;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pair <= i_pair;
        end
    end

    always_comb begin
        o_hit.match  = i_active && (r_pair.var_id == i_query.var_id);
        o_hit.differ = i_active && (r_pair.var_id == i_query.var_id)
                       && (r_pair.value_id != i_query.value_id);
    end

    assign o_pair = r_pair;

endmodule
